// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the price level book
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds every cycle outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/plob_pkg.sv =====
`default_nettype none
package plob_pkg;

    localparam int unsigned LevelsDefault = 64;
    localparam int unsigned CmdFifoDepth  = 2;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_DELETE  = 2'd1,
        REQ_CANCEL  = 2'd2,
        REQ_REPLACE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // classified command handed from front to back
    typedef struct packed {
        logic        do_del;     // remove order_qty from old level
        logic        do_sub;     // partial cancel subtract
        logic        do_add;     // add new level / merge
        logic        del_side;
        logic [31:0] del_price;
        logic [31:0] del_qty;    // order_qty, or cancel_qty for partial
        logic        add_side;
        logic [31:0] add_price;
        logic [31:0] add_qty;
        logic [31:0] order_qty;
        logic [31:0] rem_ok;     // remaining qty if all goes well
        logic        is_replace;
    } t_cmd;

    // result handed back to the output stage
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] bid_price;
        logic [31:0] bid_qty;
        logic [31:0] ask_price;
        logic [31:0] ask_qty;
        logic [31:0] rem;
    } t_res;

endpackage
`default_nettype wire

// ===== hw/rtl/plob_front.sv =====
`default_nettype none
// Accepts requests and turns them into delete/subtract/add commands, queued for the back end
module plob_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_full,
    input  wire logic [1:0]     i_req_type,
    input  wire logic           i_side,
    input  wire logic [31:0]    i_price,
    input  wire logic [31:0]    i_order_qty,
    input  wire logic [31:0]    i_cancel_qty,
    input  wire logic           i_new_side,
    input  wire logic [31:0]    i_new_price,
    input  wire logic [31:0]    i_new_qty,
    output logic                o_cmd_valid,
    output plob_pkg::t_cmd      o_cmd,
    input  wire logic           i_cmd_take
);
    plob_pkg::t_cmd r_q [plob_pkg::CmdFifoDepth];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    plob_pkg::t_cmd n_cmd;
    logic           w_wr, w_rd;

    // classify
    always_comb begin
        n_cmd = '0;
        n_cmd.del_side   = i_side;
        n_cmd.del_price  = i_price;
        n_cmd.del_qty    = i_order_qty;
        n_cmd.add_side   = i_side;
        n_cmd.add_price  = i_price;
        n_cmd.add_qty    = i_order_qty;
        n_cmd.order_qty  = i_order_qty;
        case (plob_pkg::t_req'(i_req_type))
            plob_pkg::REQ_ADD: begin
                n_cmd.do_add = 1'b1;
                n_cmd.rem_ok = i_order_qty;
            end
            plob_pkg::REQ_DELETE: begin
                n_cmd.do_del = 1'b1;
            end
            plob_pkg::REQ_CANCEL: begin
                if (i_cancel_qty >= i_order_qty) begin
                    n_cmd.do_del = 1'b1;
                end else begin
                    n_cmd.do_sub  = 1'b1;
                    n_cmd.del_qty = i_cancel_qty;
                    n_cmd.rem_ok  = i_order_qty - i_cancel_qty;
                end
            end
            plob_pkg::REQ_REPLACE: begin
                n_cmd.do_del     = 1'b1;
                n_cmd.do_add     = 1'b1;
                n_cmd.is_replace = 1'b1;
                n_cmd.add_side   = i_new_side;
                n_cmd.add_price  = i_new_price;
                n_cmd.add_qty    = i_new_qty;
                n_cmd.rem_ok     = i_new_qty;
            end
            default: n_cmd.do_add = 1'b0;
        endcase
    end

    assign o_full      = (r_cnt == 2'(plob_pkg::CmdFifoDepth));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    // command queue
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/plob_side.sv =====
`default_nettype none
// One sorted row of price level cells; combinational compare, registered shift
module plob_side #(
    parameter int unsigned LEVELS = plob_pkg::LevelsDefault,
    parameter bit          ASK    = 1'b0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // operation strobes, price/qty held stable by caller over search+apply
    input  wire logic           i_apply_del,   // delete: remove or subtract
    input  wire logic           i_apply_sub,   // partial cancel subtract
    input  wire logic           i_apply_add,
    input  wire logic [31:0]    i_price,
    input  wire logic [31:0]    i_qty,
    output logic                o_found,       // combinational on current row
    output logic                o_is_full,
    output logic [31:0]         o_top_price,
    output logic [31:0]         o_top_qty
);
    localparam int unsigned CW = $clog2(LEVELS + 1);

    logic [31:0]   r_pr [LEVELS];
    logic [31:0]   r_qt [LEVELS];
    logic [CW-1:0] r_cnt;

    logic [LEVELS-1:0] w_valid, w_hit, w_before;
    logic              w_rmv;

    // per-cell compare
    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            w_valid[i]  = (CW'(i) < r_cnt);
            w_hit[i]    = w_valid[i] && (r_pr[i] == i_price);
            // cell stays ahead of a new level
            w_before[i] = w_valid[i] && (ASK ? (r_pr[i] < i_price) : (r_pr[i] > i_price));
        end
    end

    assign o_found     = |w_hit;
    assign o_is_full   = (r_cnt == CW'(LEVELS));
    assign o_top_price = (r_cnt != '0) ? r_pr[0] : 32'd0;
    assign o_top_qty   = (r_cnt != '0) ? r_qt[0] : 32'd0;

    // hit level is removed when its qty does not exceed the amount
    always_comb begin
        w_rmv = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            if (w_hit[i] && r_qt[i] <= i_qty) w_rmv = 1'b1;
        end
    end

    // shifting cell row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_apply_add && o_found) begin
            for (int i = 0; i < LEVELS; i++) begin
                if (w_hit[i]) begin
                    r_qt[i] <= ({1'b0, r_qt[i]} + {1'b0, i_qty} > 33'hFFFF_FFFF)
                               ? 32'hFFFF_FFFF : r_qt[i] + i_qty;
                end
            end
        end else if (i_apply_add && !o_is_full) begin
            for (int i = 0; i < LEVELS; i++) begin
                if (!w_before[i]) begin
                    if (i == 0 || w_before[(i == 0) ? 0 : i-1]) begin
                        r_pr[i] <= i_price;
                        r_qt[i] <= i_qty;
                    end else begin
                        r_pr[i] <= r_pr[(i == 0) ? 0 : i-1];
                        r_qt[i] <= r_qt[(i == 0) ? 0 : i-1];
                    end
                end
            end
            r_cnt <= r_cnt + CW'(1);
        end else if ((i_apply_del || i_apply_sub) && o_found) begin
            if (i_apply_del && w_rmv) begin
                for (int i = 0; i < LEVELS; i++) begin
                    if (w_hit[i] || (i > 0 && |(w_hit & ((LEVELS)'(1) << i) - 1'b1) == 1'b1
                        && (|(w_hit & (((LEVELS)'(1) << i) - 1'b1))))) begin
                        if (i == LEVELS - 1) begin
                            r_pr[i] <= 32'd0;
                            r_qt[i] <= 32'd0;
                        end else begin
                            r_pr[i] <= r_pr[(i == LEVELS-1) ? i : i+1];
                            r_qt[i] <= r_qt[(i == LEVELS-1) ? i : i+1];
                        end
                    end
                end
                r_cnt <= r_cnt - CW'(1);
            end else begin
                for (int i = 0; i < LEVELS; i++) begin
                    if (w_hit[i]) begin
                        r_qt[i] <= (r_qt[i] >= i_qty) ? r_qt[i] - i_qty : 32'd0;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/plob_back.sv =====
`default_nettype none
// Executes commands on both rows: delete phase, add phase, then result
module plob_back #(
    parameter int unsigned LEVELS = plob_pkg::LevelsDefault
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    input  plob_pkg::t_cmd      i_cmd,
    output logic                o_cmd_take,
    output logic                o_res_valid,
    output plob_pkg::t_res      o_res,
    input  wire logic           i_res_take
);
    typedef enum logic [1:0] {S_DEL, S_ADD, S_OUT} t_state;

    t_state         r_state;
    logic           r_dst;        // delete phase status not found
    logic           r_full;
    logic           r_res_valid;
    plob_pkg::t_res r_res;

    logic        w_bfound, w_afound, w_bfull, w_afull;
    logic [31:0] w_bbp, w_bbq, w_bap, w_baq;
    logic        w_go;
    logic [31:0] w_price, w_qty;
    logic        w_side;
    logic        w_del, w_sub, w_add;
    logic        w_found, w_sfull;

    // only the result phase waits for the result register to free up
    assign w_go   = i_cmd_valid && ((r_state != S_OUT) || !r_res_valid || i_res_take);
    assign w_side = (r_state == S_ADD) ? i_cmd.add_side : i_cmd.del_side;
    assign w_price = (r_state == S_ADD) ? i_cmd.add_price : i_cmd.del_price;
    assign w_qty   = (r_state == S_ADD) ? i_cmd.add_qty : i_cmd.del_qty;
    assign w_del  = w_go && (r_state == S_DEL) && i_cmd.do_del;
    assign w_sub  = w_go && (r_state == S_DEL) && i_cmd.do_sub;
    assign w_add  = w_go && (r_state == S_ADD) && i_cmd.do_add;
    assign w_found = w_side ? w_afound : w_bfound;
    assign w_sfull = w_side ? w_afull : w_bfull;

    plob_side #(.LEVELS(LEVELS), .ASK(1'b0)) u_bid (
        .i_clk, .i_rst_n,
        .i_apply_del(w_del && !w_side), .i_apply_sub(w_sub && !w_side),
        .i_apply_add(w_add && !w_side), .i_price(w_price), .i_qty(w_qty),
        .o_found(w_bfound), .o_is_full(w_bfull), .o_top_price(w_bbp), .o_top_qty(w_bbq)
    );
    plob_side #(.LEVELS(LEVELS), .ASK(1'b1)) u_ask (
        .i_clk, .i_rst_n,
        .i_apply_del(w_del && w_side), .i_apply_sub(w_sub && w_side),
        .i_apply_add(w_add && w_side), .i_price(w_price), .i_qty(w_qty),
        .o_found(w_afound), .o_is_full(w_afull), .o_top_price(w_bap), .o_top_qty(w_baq)
    );

    assign o_cmd_take  = w_go && (r_state == S_OUT);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_DEL;
            r_dst       <= 1'b0;
            r_full      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= (r_res_valid && !i_res_take) || (w_go && (r_state == S_OUT));
            if (w_go) begin
                case (r_state)
                    S_DEL: begin
                        r_dst   <= (i_cmd.do_del || i_cmd.do_sub) && !w_found;
                        r_full  <= 1'b0;
                        r_state <= S_ADD;
                    end
                    S_ADD: begin
                        r_full  <= i_cmd.do_add && !w_found && w_sfull;
                        r_state <= S_OUT;
                    end
                    S_OUT: begin
                        r_res.bid_price <= w_bbp;
                        r_res.bid_qty   <= w_bbq;
                        r_res.ask_price <= w_bap;
                        r_res.ask_qty   <= w_baq;
                        if (r_full) begin
                            r_res.status <= plob_pkg::ST_FULL;
                            r_res.rem    <= 32'd0;
                        end else if (r_dst) begin
                            r_res.status <= plob_pkg::ST_NOT_FOUND;
                            r_res.rem    <= i_cmd.is_replace ? i_cmd.rem_ok : i_cmd.order_qty;
                        end else begin
                            r_res.status <= plob_pkg::ST_OK;
                            r_res.rem    <= i_cmd.rem_ok;
                        end
                        r_state <= S_DEL;
                    end
                    default: r_state <= S_DEL;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/price_level_order_book.sv =====
// Price level order book.
// Input channel: queue style, i_push with o_full; a request is taken at a clock
// edge with i_push high and o_full low. Fields: type, side, price, quantities.
// Result channel: queue style, o_empty with i_pop; the result stays on the ports
// while o_empty is low and is taken at an edge with i_pop high.
// A two-entry request queue decouples intake from execution.
// In the executor a request runs a delete/cancel phase, an add phase and a result
// phase; the first two each compare and shift across the level cells of one side,
// and the result phase registers the result. The executor ends one request before
// it starts the next; o_empty falls when the result phase completes.
// While a result waits unpopped the executor runs the delete and add phases of
// the next request and then holds in its result phase; the request queue fills
// up to two entries before o_full rises.
// Synchronous reset empties both sides, the queue and the result register.
`default_nettype none
`include "assert_macros.svh"
module price_level_order_book #(
    parameter int unsigned LEVELS = plob_pkg::LevelsDefault
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_full,
    input  wire logic [1:0]     i_req_type,
    input  wire logic           i_side,
    input  wire logic [31:0]    i_price,
    input  wire logic [31:0]    i_order_qty,
    input  wire logic [31:0]    i_cancel_qty,
    input  wire logic           i_new_side,
    input  wire logic [31:0]    i_new_price,
    input  wire logic [31:0]    i_new_qty,
    output logic                o_empty,
    input  wire logic           i_pop,
    output logic [1:0]          o_status,
    output logic [31:0]         o_best_bid_price,
    output logic [31:0]         o_best_bid_qty,
    output logic [31:0]         o_best_ask_price,
    output logic [31:0]         o_best_ask_qty,
    output logic [31:0]         o_remaining_qty
);
    logic           w_cmd_valid, w_cmd_take, w_res_valid;
    plob_pkg::t_cmd w_cmd;
    plob_pkg::t_res w_res;

    plob_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full,
        .i_req_type, .i_side, .i_price, .i_order_qty, .i_cancel_qty,
        .i_new_side, .i_new_price, .i_new_qty,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    plob_back #(.LEVELS(LEVELS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_take(w_cmd_take),
        .o_res_valid(w_res_valid), .o_res(w_res), .i_res_take(i_pop)
    );

    assign o_empty          = !w_res_valid;
    assign o_status         = w_res.status;
    assign o_best_bid_price = w_res.bid_price;
    assign o_best_bid_qty   = w_res.bid_qty;
    assign o_best_ask_price = w_res.ask_price;
    assign o_best_ask_qty   = w_res.ask_qty;
    assign o_remaining_qty  = w_res.rem;

    // checks
    `ASSERT_ALWAYS(a_status_code, i_clk, i_rst_n, o_empty || o_status != 2'd3, "bad status")
    `ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_remaining_qty), "result dropped")
    `ASSERT_NEXT(a_take_done, i_clk, i_rst_n, w_cmd_take, !o_empty, "no result after command")
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOOK_DEPTH = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [1:0]  i_req_type;
    logic        i_side;
    logic [31:0] i_price;
    logic [31:0] i_order_qty;
    logic [31:0] i_cancel_qty;
    logic        i_new_side;
    logic [31:0] i_new_price;
    logic [31:0] i_new_qty;
    logic        o_empty;
    logic        i_pop;
    logic [1:0]  o_status;
    logic [31:0] o_best_bid_price;
    logic [31:0] o_best_bid_qty;
    logic [31:0] o_best_ask_price;
    logic [31:0] o_best_ask_qty;
    logic [31:0] o_remaining_qty;

    price_level_order_book #(.LEVELS(BOOK_DEPTH)) uut (.*);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] bid_price;
        logic [31:0] bid_qty;
        logic [31:0] ask_price;
        logic [31:0] ask_qty;
        logic [31:0] rem;
    } t_book_result;

    // predicted book: index 0 is bid side, 1 is ask side
    logic [31:0] lvl_price [2][BOOK_DEPTH];
    logic [31:0] lvl_qty   [2][BOOK_DEPTH];
    int          lvl_count [2];

    t_book_result pending_results[$];
    int  error_count;
    int  sent_count;
    int  result_count;
    bit  no_idle;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // safety net
    initial begin
        #50ms;
        $display("TIMEOUT at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int find_level(input bit s, input logic [31:0] p);
        for (int i = 0; i < lvl_count[s]; i++)
            if (lvl_price[s][i] == p) return i;
        return -1;
    endfunction

    function automatic plob_pkg::t_status book_add(input bit s, input logic [31:0] p,
                                                   input logic [31:0] q);
        int idx;
        int pos;
        logic [32:0] sum;
        idx = find_level(s, p);
        if (idx >= 0) begin
            sum = {1'b0, lvl_qty[s][idx]} + {1'b0, q};
            lvl_qty[s][idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            return plob_pkg::ST_OK;
        end
        if (lvl_count[s] >= BOOK_DEPTH) return plob_pkg::ST_FULL;
        pos = 0;
        while (pos < lvl_count[s] &&
               !(s ? (lvl_price[s][pos] >= p) : (lvl_price[s][pos] <= p)))
            pos++;
        for (int i = lvl_count[s]; i > pos; i--) begin
            lvl_price[s][i] = lvl_price[s][i-1];
            lvl_qty[s][i]   = lvl_qty[s][i-1];
        end
        lvl_price[s][pos] = p;
        lvl_qty[s][pos]   = q;
        lvl_count[s]++;
        return plob_pkg::ST_OK;
    endfunction

    function automatic plob_pkg::t_status book_remove(input bit s, input logic [31:0] p,
                                                      input logic [31:0] q);
        int idx;
        int n;
        idx = find_level(s, p);
        n = lvl_count[s];
        if (idx < 0) return plob_pkg::ST_NOT_FOUND;
        if (lvl_qty[s][idx] <= q) begin
            for (int i = idx; i + 1 < n; i++) begin
                lvl_price[s][i] = lvl_price[s][i+1];
                lvl_qty[s][i]   = lvl_qty[s][i+1];
            end
            lvl_price[s][n-1] = '0;
            lvl_qty[s][n-1]   = '0;
            lvl_count[s]--;
        end else begin
            lvl_qty[s][idx] -= q;
        end
        return plob_pkg::ST_OK;
    endfunction

    // apply one request to the predicted book and return the expected result
    function automatic t_book_result apply_request(
        input plob_pkg::t_req rt, input bit s, input logic [31:0] p,
        input logic [31:0] oq, input logic [31:0] cq, input bit ns,
        input logic [31:0] np, input logic [31:0] nq);
        t_book_result r;
        plob_pkg::t_status st;
        plob_pkg::t_status ds;
        int idx;
        st = plob_pkg::ST_OK;
        r.rem = '0;
        case (rt)
            plob_pkg::REQ_ADD: begin
                st = book_add(s, p, oq);
                r.rem = (st == plob_pkg::ST_OK) ? oq : '0;
            end
            plob_pkg::REQ_DELETE: begin
                st = book_remove(s, p, oq);
                r.rem = (st == plob_pkg::ST_OK) ? '0 : oq;
            end
            plob_pkg::REQ_CANCEL: begin
                if (cq >= oq) begin
                    st = book_remove(s, p, oq);
                    r.rem = (st == plob_pkg::ST_OK) ? '0 : oq;
                end else begin
                    idx = find_level(s, p);
                    if (idx < 0) begin
                        st = plob_pkg::ST_NOT_FOUND;
                        r.rem = oq;
                    end else begin
                        lvl_qty[s][idx] = (lvl_qty[s][idx] >= cq) ?
                                          lvl_qty[s][idx] - cq : '0;
                        r.rem = oq - cq;
                    end
                end
            end
            default: begin
                ds = book_remove(s, p, oq);
                st = book_add(ns, np, nq);
                if (st == plob_pkg::ST_FULL) r.rem = '0;
                else begin
                    st = ds;
                    r.rem = nq;
                end
            end
        endcase
        r.status    = st;
        r.bid_price = lvl_count[0] ? lvl_price[0][0] : '0;
        r.bid_qty   = lvl_count[0] ? lvl_qty[0][0] : '0;
        r.ask_price = lvl_count[1] ? lvl_price[1][0] : '0;
        r.ask_qty   = lvl_count[1] ? lvl_qty[1][0] : '0;
        return r;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 22);
    endfunction

    // send one request transaction and record its expected result
    task automatic send_request(input plob_pkg::t_req rt, input bit s,
                                input logic [31:0] p,
                                input logic [31:0] oq, input logic [31:0] cq,
                                input bit ns, input logic [31:0] np,
                                input logic [31:0] nq);
        while (idle_now()) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push       <= 1'b1;
        i_req_type   <= rt;
        i_side       <= s;
        i_price      <= p;
        i_order_qty  <= oq;
        i_cancel_qty <= cq;
        i_new_side   <= ns;
        i_new_price  <= np;
        i_new_qty    <= nq;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        pending_results.push_back(apply_request(rt, s, p, oq, cq, ns, np, nq));
        sent_count++;
    endtask

    // result side: random pop stalls and field checks
    always @(posedge i_clk) begin
        t_book_result exp_r;
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, status %0d", $time, o_status);
                    error_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_status !== exp_r.status) begin
                        $display("%0t: status exp %0d got %0d", $time,
                                 exp_r.status, o_status);
                        error_count++;
                    end
                    if (o_best_bid_price !== exp_r.bid_price) begin
                        $display("%0t: bid price exp %0h got %0h", $time,
                                 exp_r.bid_price, o_best_bid_price);
                        error_count++;
                    end
                    if (o_best_bid_qty !== exp_r.bid_qty) begin
                        $display("%0t: bid qty exp %0h got %0h", $time,
                                 exp_r.bid_qty, o_best_bid_qty);
                        error_count++;
                    end
                    if (o_best_ask_price !== exp_r.ask_price) begin
                        $display("%0t: ask price exp %0h got %0h", $time,
                                 exp_r.ask_price, o_best_ask_price);
                        error_count++;
                    end
                    if (o_best_ask_qty !== exp_r.ask_qty) begin
                        $display("%0t: ask qty exp %0h got %0h", $time,
                                 exp_r.ask_qty, o_best_ask_qty);
                        error_count++;
                    end
                    if (o_remaining_qty !== exp_r.rem) begin
                        $display("%0t: remaining exp %0h got %0h", $time,
                                 exp_r.rem, o_remaining_qty);
                        error_count++;
                    end
                end
            end
            i_pop <= !idle_now();
        end
    end

    function automatic logic [31:0] rand_word();
        return $urandom();
    endfunction

    // price of an existing level of the side, or a fresh one
    function automatic logic [31:0] pick_price(input bit s);
        if (lvl_count[s] > 0 && $urandom_range(99) < 70)
            return lvl_price[s][$urandom_range(lvl_count[s] - 1)];
        if ($urandom_range(9) == 0) return rand_word();
        return 32'd1000 + $urandom_range(120);
    endfunction

    function automatic logic [31:0] pick_qty();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return rand_word();
            default: return $urandom_range(1, 500);
        endcase
    endfunction

    // field extremes, every request type, each corner
    task automatic test_directed();
        send_request(plob_pkg::REQ_DELETE, 1'b0, 32'd5, 32'd7, '0, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_CANCEL, 1'b1, 32'd5, 32'd7, 32'd2, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_ADD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b0,
                     '0, '0);
        send_request(plob_pkg::REQ_ADD, 1'b0, 32'hFFFF_FFFF, 32'd10, '0, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_ADD, 1'b1, 32'd0, 32'd0, '0, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_ADD, 1'b1, 32'd100, 32'd50, '0, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_ADD, 1'b0, 32'd90, 32'd40, '0, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_ADD, 1'b0, 32'd95, 32'd30, '0, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_CANCEL, 1'b0, 32'd95, 32'd100, 32'd60, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_CANCEL, 1'b0, 32'd90, 32'd20, 32'd20, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_CANCEL, 1'b0, 32'd90, 32'd20, 32'hFFFF_FFFF, 1'b0,
                     '0, '0);
        send_request(plob_pkg::REQ_DELETE, 1'b1, 32'd0, 32'd0, '0, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_DELETE, 1'b1, 32'd100, 32'd10, '0, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_REPLACE, 1'b1, 32'd100, 32'd40, 32'hFFFF_FFFF, 1'b0,
                     32'd96, 32'd25);
        send_request(plob_pkg::REQ_REPLACE, 1'b0, 32'd7, 32'd1, '0, 1'b1,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(plob_pkg::REQ_DELETE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b1,
                     '0, '0);
        // fill the ask side, then overflow it by add and replace
        for (int i = 0; i < BOOK_DEPTH; i++)
            send_request(plob_pkg::REQ_ADD, 1'b1, 32'd2000 + i, 32'd1, '0, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_ADD, 1'b1, 32'd1, 32'd5, '0, 1'b0, '0, '0);
        send_request(plob_pkg::REQ_REPLACE, 1'b0, 32'd3, 32'd1, '0, 1'b1, 32'd4, 32'd9);
        send_request(plob_pkg::REQ_REPLACE, 1'b1, 32'd2000, 32'd1, '0, 1'b1, 32'd4,
                     32'd9);
        // drain the asks again
        while (lvl_count[1] > 0)
            send_request(plob_pkg::REQ_DELETE, 1'b1, lvl_price[1][0], 32'hFFFF_FFFF, '0,
                         1'b0, '0, '0);
    endtask

    // random mix, mostly against live levels
    task automatic test_random(input int n_items);
        bit s;
        logic [31:0] oq;
        for (int k = 0; k < n_items; k++) begin
            no_idle = (k >= n_items / 2) && (k < n_items / 2 + 250);
            s = $urandom_range(1);
            oq = pick_qty();
            case ($urandom_range(9))
                0, 1, 2, 3: send_request(plob_pkg::REQ_ADD, s, pick_price(s), oq,
                                         rand_word(), $urandom_range(1), rand_word(),
                                         rand_word());
                4, 5: send_request(plob_pkg::REQ_DELETE, s, pick_price(s), oq,
                                   rand_word(), $urandom_range(1), rand_word(),
                                   rand_word());
                6, 7: send_request(plob_pkg::REQ_CANCEL, s, pick_price(s), oq,
                                   ($urandom_range(3) == 0) ? rand_word() :
                                   $urandom_range(0, 600), $urandom_range(1),
                                   rand_word(), rand_word());
                default: begin
                    send_request(plob_pkg::REQ_REPLACE, s, pick_price(s), oq,
                                 rand_word(), $urandom_range(1),
                                 32'd1000 + $urandom_range(120), pick_qty());
                end
            endcase
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int wait_cycles;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_req_type = plob_pkg::REQ_ADD;
        i_side = 1'b0;
        i_price = '0;
        i_order_qty = '0;
        i_cancel_qty = '0;
        i_new_side = 1'b0;
        i_new_price = '0;
        i_new_qty = '0;
        error_count = 0;
        sent_count = 0;
        result_count = 0;
        no_idle = 1'b0;
        lvl_count[0] = 0;
        lvl_count[1] = 0;
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            lvl_price[0][i] = '0; lvl_qty[0][i] = '0;
            lvl_price[1][i] = '0; lvl_qty[1][i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(1650);
        i_push <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests of all four types, checked %0d results;",
                 sent_count, result_count);
        $display("covered full sides, saturation, absent levels and replaces.");
        if (error_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
